>>> hdl/soa_pkg.sv
`default_nettype none
package soa_pkg;
	localparam int NUM_SLABS = 8;
	localparam int MAX_OBJS = 256;
	localparam int SLAB_W = 3;
	localparam int IDX_W = 8;
	localparam int ADDR_W = SLAB_W + IDX_W;
	localparam int LINK_W = 9;
	localparam int LIST_W = 4;
	localparam logic [LINK_W-1:0] LINK_END = 9'd511;
	localparam logic [LIST_W-1:0] NO_SLAB = 4'd15;
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;
	localparam logic REG_OBJECT_SIZE = 1'b0;
	localparam logic REG_OBJS_PER_SLAB = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FILL,
		ST_RD,
		ST_POP
	} state_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    waddr;
		logic [LINK_W-1:0]    wdata;
		logic                 re;
		logic [ADDR_W-1:0]    raddr;
	} ram_req_t;
endpackage
`default_nettype wire

>>> hdl/soa_link_ram.sv
`default_nettype none
module soa_link_ram (
	input  wire logic                           clk,
	input  wire soa_pkg::ram_req_t              req,
	output logic [soa_pkg::LINK_W-1:0]          rdata
);
	logic [soa_pkg::LINK_W-1:0] mem [soa_pkg::NUM_SLABS*soa_pkg::MAX_OBJS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end
endmodule
`default_nettype wire

>>> hdl/slab_object_allocator.sv
// Slab allocator over eight slab slots of up to 256 objects. Each item is an
// allocate or a free and gives exactly one result. A free is settled in the
// exec state, an allocate from a slab on the partial list goes through exec,
// read and pop, and one that has to claim a new slot first writes each object
// link into the link memory in the fill state. One item is worked at a time;
// the output register lets the next item in while a result waits.
`default_nettype none
module slab_object_allocator (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [12:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [15:0]  s_tdata,   // slab_id, obj_index, zero pad
	input  wire logic         s_tuser,   // func
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [47:0]       m_tdata,   // got_slab, got_index, byte_offset,
	                                     // slab_released, free_total, slab_total
	output logic              m_tuser    // status
);
	localparam int NS = soa_pkg::NUM_SLABS;

	soa_pkg::state_t state_q, state_d;

	logic [12:0] osize_q;
	logic [8:0]  ops_q;

	logic                       func_q;
	logic [soa_pkg::SLAB_W-1:0] sid_q;
	logic [soa_pkg::IDX_W-1:0]  oidx_q;
	logic [soa_pkg::SLAB_W-1:0] s_q;
	logic [soa_pkg::IDX_W-1:0]  idx_q;
	logic [soa_pkg::IDX_W-1:0]  fill_q;

	logic [soa_pkg::LINK_W-1:0] first_free_q [NS];
	logic [8:0]                 cnt_q [NS];
	logic [NS-1:0]              claimed_q;
	logic [soa_pkg::LIST_W-1:0] lnext_q [NS];
	logic [soa_pkg::LIST_W-1:0] lprev_q [NS];
	logic [soa_pkg::LIST_W-1:0] lfirst_q;
	logic [11:0]                total_q;
	logic [3:0]                 ccount_q;

	soa_pkg::ram_req_t          req;
	logic [soa_pkg::LINK_W-1:0] rdata;

	soa_link_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

	// config clamps
	logic [13:0] osz_round;
	logic [12:0] osz_new;
	logic [8:0]  ops_new;
	always_comb begin
		osz_round = ({1'b0, cfg_data} + 14'd15) & ~14'd15;
		if (osz_round > 14'd4096) osz_new = 13'd4096;
		else if (osz_round < 14'd16) osz_new = 13'd16;
		else osz_new = osz_round[12:0];
		if (cfg_data[8:0] < 9'd4) ops_new = 9'd4;
		else if (cfg_data[8:0] > 9'd256) ops_new = 9'd256;
		else ops_new = cfg_data[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osize_q <= 13'd16;
			ops_q <= 9'd4;
		end else if (cfg_we) begin
			if (cfg_index == soa_pkg::REG_OBJECT_SIZE) osize_q <= osz_new;
			else ops_q <= ops_new;
		end
	end

	// lowest unclaimed slot
	logic                       have_slot;
	logic [soa_pkg::SLAB_W-1:0] free_slot;
	always_comb begin
		have_slot = 1'b0;
		free_slot = '0;
		for (int k = NS - 1; k >= 0; k--) begin
			if (!claimed_q[k]) begin
				have_slot = 1'b1;
				free_slot = soa_pkg::SLAB_W'(k);
			end
		end
	end

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	logic [8:0] fcnt;
	logic       free_ok;
	logic       list_ok;
	logic       fill_last;
	logic [8:0] fill_nxt;
	logic [soa_pkg::IDX_W-1:0] head_idx;
	always_comb begin
		fcnt = cnt_q[sid_q];
		free_ok = claimed_q[sid_q] && ({1'b0, oidx_q} < ops_q) && (fcnt < ops_q);
		list_ok = lfirst_q < soa_pkg::LIST_W'(NS);
		fill_nxt = {1'b0, fill_q} + 9'd1;
		fill_last = fill_nxt >= ops_q;
		head_idx = first_free_q[s_q][8] ? '0 : first_free_q[s_q][7:0];
	end

	// free outcome and result load
	logic        free_rel;
	logic [11:0] free_tot;
	logic [3:0]  free_cc;
	logic        out_load;
	always_comb begin
		free_rel = free_ok && (fcnt + 9'd1 == ops_q);
		if (!free_ok) free_tot = total_q;
		else if (free_rel) free_tot = total_q - 12'(fcnt);
		else free_tot = total_q + 12'd1;
		free_cc = free_rel ? ccount_q - 4'd1 : ccount_q;
		out_load = 1'b0;
		if (state_q == soa_pkg::ST_EXEC && out_free)
			out_load = (func_q != soa_pkg::FUNC_ALLOC) || (!list_ok && !have_slot);
		else if (state_q == soa_pkg::ST_POP && out_free)
			out_load = 1'b1;
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		req = '0;
		case (state_q)
			soa_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = soa_pkg::ST_EXEC;
			end
			soa_pkg::ST_EXEC: begin
				if (func_q == soa_pkg::FUNC_ALLOC) begin
					if (list_ok) state_d = soa_pkg::ST_RD;
					else if (have_slot) state_d = soa_pkg::ST_FILL;
					else if (out_free) state_d = soa_pkg::ST_IDLE;
				end else if (out_free) begin
					state_d = soa_pkg::ST_IDLE;
					if (free_ok && (fcnt + 9'd1 != ops_q)) begin
						req.we = 1'b1;
						req.waddr = {sid_q, oidx_q};
						req.wdata = first_free_q[sid_q];
					end
				end
			end
			soa_pkg::ST_FILL: begin
				req.we = 1'b1;
				req.waddr = {s_q, fill_q};
				req.wdata = fill_last ? soa_pkg::LINK_END : fill_nxt;
				if (fill_last) state_d = soa_pkg::ST_RD;
			end
			soa_pkg::ST_RD: begin
				req.re = 1'b1;
				req.raddr = {s_q, head_idx};
				state_d = soa_pkg::ST_POP;
			end
			soa_pkg::ST_POP: begin
				if (out_free) state_d = soa_pkg::ST_IDLE;
			end
			default: state_d = soa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= soa_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == soa_pkg::ST_IDLE && s_tvalid) begin
			func_q <= s_tuser;
			sid_q <= s_tdata[2:0];
			oidx_q <= s_tdata[10:3];
		end
	end

	logic [soa_pkg::LIST_W-1:0] sp, sn;
	logic [8:0] cnt_dec;
	always_comb begin
		sp = lprev_q[sid_q];
		sn = lnext_q[sid_q];
		if (state_q == soa_pkg::ST_POP) begin
			sp = lprev_q[s_q];
			sn = lnext_q[s_q];
		end
		cnt_dec = cnt_q[s_q] - 9'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (out_load) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q <= '0;
			lfirst_q <= soa_pkg::NO_SLAB;
			total_q <= '0;
			ccount_q <= '0;
			for (int k = 0; k < NS; k++) cnt_q[k] <= '0;
		end else begin
			case (state_q)
				soa_pkg::ST_EXEC: begin
					if (func_q == soa_pkg::FUNC_ALLOC) begin
						if (list_ok) begin
							s_q <= lfirst_q[soa_pkg::SLAB_W-1:0];
						end else if (have_slot) begin
							s_q <= free_slot;
							fill_q <= '0;
						end else if (out_free) begin
							m_tuser <= 1'b1;
							m_tdata <= {ccount_q, total_q, 1'b0, 20'd0, 8'd0, 3'd0};
						end
					end else if (out_free) begin
						m_tuser <= 1'b0;
						m_tdata <= {free_cc, free_tot, free_rel, 20'd0, 8'd0, 3'd0};
						total_q <= free_tot;
						ccount_q <= free_cc;
						if (free_rel) begin
							if (fcnt != 9'd0) begin
								if (sp < soa_pkg::LIST_W'(NS))
									lnext_q[sp[soa_pkg::SLAB_W-1:0]] <= sn;
								else lfirst_q <= sn;
								if (sn < soa_pkg::LIST_W'(NS))
									lprev_q[sn[soa_pkg::SLAB_W-1:0]] <= sp;
								lnext_q[sid_q] <= soa_pkg::NO_SLAB;
								lprev_q[sid_q] <= soa_pkg::NO_SLAB;
							end
							claimed_q[sid_q] <= 1'b0;
							cnt_q[sid_q] <= '0;
						end else if (free_ok) begin
							cnt_q[sid_q] <= fcnt + 9'd1;
							first_free_q[sid_q] <= {1'b0, oidx_q};
							if (fcnt == 9'd0) begin
								lprev_q[sid_q] <= soa_pkg::NO_SLAB;
								lnext_q[sid_q] <= lfirst_q;
								if (lfirst_q < soa_pkg::LIST_W'(NS))
									lprev_q[lfirst_q[soa_pkg::SLAB_W-1:0]] <=
										{1'b0, sid_q};
								lfirst_q <= {1'b0, sid_q};
							end
						end
					end
				end
				soa_pkg::ST_FILL: begin
					fill_q <= fill_nxt[7:0];
					if (fill_last) begin
						claimed_q[s_q] <= 1'b1;
						first_free_q[s_q] <= '0;
						cnt_q[s_q] <= ops_q;
						ccount_q <= ccount_q + 4'd1;
						total_q <= total_q + 12'(ops_q);
						lprev_q[s_q] <= soa_pkg::NO_SLAB;
						lnext_q[s_q] <= lfirst_q;
						lfirst_q <= {1'b0, s_q};
					end
				end
				soa_pkg::ST_RD: begin
					idx_q <= head_idx;
				end
				soa_pkg::ST_POP: begin
					if (out_free) begin
						total_q <= total_q - 12'd1;
						cnt_q[s_q] <= cnt_dec;
						first_free_q[s_q] <= rdata;
						if (cnt_dec == 9'd0) begin
							if (sp < soa_pkg::LIST_W'(NS))
								lnext_q[sp[soa_pkg::SLAB_W-1:0]] <= sn;
							else lfirst_q <= sn;
							if (sn < soa_pkg::LIST_W'(NS))
								lprev_q[sn[soa_pkg::SLAB_W-1:0]] <= sp;
							lnext_q[s_q] <= soa_pkg::NO_SLAB;
							lprev_q[s_q] <= soa_pkg::NO_SLAB;
						end
						m_tuser <= 1'b0;
						m_tdata <= {ccount_q, total_q - 12'd1, 1'b0,
							(20'(idx_q) * 20'(osize_q)), idx_q, s_q};
					end
				end
				default: ;
			endcase
		end
	end

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		ccount_q == 4'($countones(claimed_q)))
		else $error("claimed count out of step");
	a_head_claimed: assert property (@(posedge clk) disable iff (!arst_n)
		lfirst_q < soa_pkg::LIST_W'(NS) |-> claimed_q[lfirst_q[soa_pkg::SLAB_W-1:0]])
		else $error("list head not claimed");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == soa_pkg::ST_POP |-> cnt_q[s_q] != 9'd0)
		else $error("pop from full slab");
endmodule
`default_nettype wire
